@@ rtl/core/psk_pkg.sv @@
// ----------------------------------------------------------------------------
// psk_pkg: shared types and constants for the polyphonic sine key synth
// Field widths, register indexes, reset values, and the quarter-wave
// sine and reciprocal tables.
// ----------------------------------------------------------------------------
`default_nettype none

package psk_pkg;

	localparam int MASK_W      = 7;
	localparam int STEP_W      = 24;
	localparam int VOL_W       = 15;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int STEP_REGS   = 7;
	localparam int STEP_IDX_W  = 3;
	localparam int TAB_W       = 15;
	localparam int GAIN_W      = 13;
	localparam int G2K_W       = 23;
	localparam int PCM_W       = 12;
	localparam int CNT_W       = 3;
	localparam int MUL_DIG     = 4;
	localparam int RND_SHIFT   = 27;
	localparam int TAB_MAX     = 32767;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_STEP_C = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_D = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_E = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_F = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_G = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_A = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_B = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 3'd7;

	localparam logic [STEP_W-1:0] STEP_RESET [STEP_REGS] = '{
		24'd438942, 24'd492680, 24'd553027, 24'd585911,
		24'd657667, 24'd738198, 24'd828593
	};
	localparam logic [VOL_W-1:0]  VOL_RESET = 15'd4096;
	localparam logic [GAIN_W-1:0] GAIN_ONE  = 13'd4096;
	localparam logic [G2K_W-1:0]  AMP_SCALE = 23'd2000;
	localparam logic [PCM_W-1:0]  PCM_MID   = 12'd2048;
	localparam logic [PCM_W-1:0]  PCM_POS_MAX = 12'd2047;
	localparam logic [PCM_W-1:0]  PCM_TOP   = 12'hfff;
	localparam logic [PCM_W-1:0]  PCM_BOT   = 12'h000;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef logic [TAB_W-1:0] tab_word_t;

	// quarter-wave entry i: 32767*sin((2i+1)*pi/(4Q)), integer Taylor series in Q30
	function automatic tab_word_t qtab_entry(input int unsigned i, input int unsigned qbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] v;
		x    = (64'(2 * i + 1) * PI_Q30) >> (qbits + 2);
		x2   = (x * x) >> 30;
		term = x;
		acc  = x;
		term = ((term * x2) >> 30) / 64'd6;
		acc  = acc - term;
		term = ((term * x2) >> 30) / 64'd20;
		acc  = acc + term;
		term = ((term * x2) >> 30) / 64'd42;
		acc  = acc - term;
		term = ((term * x2) >> 30) / 64'd72;
		acc  = acc + term;
		term = ((term * x2) >> 30) / 64'd110;
		acc  = acc - term;
		term = ((term * x2) >> 30) / 64'd156;
		acc  = acc + term;
		term = ((term * x2) >> 30) / 64'd210;
		acc  = acc - term;
		v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'(TAB_MAX)) begin
			v = 64'(TAB_MAX);
		end
		return TAB_W'(v);
	endfunction

	// Q12 reciprocal of the active key count, rounded; no keys gives 1.0
	function automatic logic [GAIN_W-1:0] recip_q12(input logic [CNT_W-1:0] n);
		logic [GAIN_W-1:0] r;
		case (n)
			3'd2:    r = 13'd2048;
			3'd3:    r = 13'd1365;
			3'd4:    r = 13'd1024;
			3'd5:    r = 13'd819;
			3'd6:    r = 13'd683;
			3'd7:    r = 13'd585;
			default: r = GAIN_ONE;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/psk_ser_mul.sv @@
// ----------------------------------------------------------------------------
// psk_ser_mul: digit-serial unsigned multiplier
// Shifts the multiplier out DIG bits per cycle; the partial sum shifts
// down through the same register, so a*b is ready once busy falls.
// ----------------------------------------------------------------------------
`default_nettype none

module psk_ser_mul #(
	parameter int A_W = 18,
	parameter int B_W = 23,
	parameter int DIG = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [A_W-1:0]   a,
	input  wire logic [B_W-1:0]   b,
	output logic                  busy,
	output logic [A_W+B_W-1:0]    prod
);

	localparam int NDIG  = (B_W + DIG - 1) / DIG;
	localparam int BP    = NDIG * DIG;
	localparam int CNT_W = $clog2(NDIG + 1);

	logic [A_W-1:0]    a_q;
	logic [A_W+BP-1:0] p_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [A_W+DIG-1:0] hi;

	// upper half plus a times the low digit; never exceeds A_W+DIG bits
	assign hi = (A_W+DIG)'(p_q[A_W+BP-1:BP])
		+ (A_W+DIG)'(a_q) * (A_W+DIG)'(p_q[DIG-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start && !busy_q) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NDIG);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q <= a;
			p_q <= {A_W'(0), BP'(b)};
		end else if (busy_q) begin
			p_q <= {hi, p_q[BP-1:DIG]};
		end
	end

	assign busy = busy_q;
	assign prod = p_q[A_W+B_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/polyphonic_sine_key_synth_core.sv @@
// ----------------------------------------------------------------------------
// polyphonic_sine_key_synth_core: seven-key sine synthesizer, 12-bit DAC out
// Per-key phase accumulators, shared quarter-wave table, volume scaled by the
// reciprocal of the held-key count, rounded and saturated to a DAC code.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------
//  key      | key_valid / key_stall      | key_mask[6:0]
//  pcm      | pcm_valid / pcm_stall      | pcm_sample[11:0], clipped
//  cfg      | cfg_wr_en                  | cfg_index[2:0], cfg_data[23:0]
//
//  Each item passes through accept, a walk over every key, a drain of the table
//  pipe and of the multiplier, gain, multiply start, the serial multiply, load.
//  Volume times reciprocal runs on the same multiplier while keys are walked.
//  Reset clears phases, restores register defaults and empties the output.
//  A stalled pcm output holds; the next item is still taken and waits at S_OUT.
// ----------------------------------------------------------------------------
`default_nettype none

module polyphonic_sine_key_synth_core
	import psk_pkg::*;
#(
	parameter int NUM_KEYS       = 7,
	parameter int PHASE_BITS     = 24,
	parameter int SINE_ADDR_BITS = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  key_valid,
	output logic                       key_stall,
	input  wire logic [MASK_W-1:0]     key_mask,
	output logic                       pcm_valid,
	input  wire logic                  pcm_stall,
	output logic [PCM_W-1:0]           pcm_sample,
	output logic                       clipped,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int LIVE  = (NUM_KEYS < STEP_REGS) ? NUM_KEYS : STEP_REGS;
	localparam int KEY_W = (LIVE > 1) ? $clog2(LIVE) : 1;
	localparam int QBITS = SINE_ADDR_BITS - 2;
	localparam int QSIZE = 1 << QBITS;
	localparam int MAG_W = $clog2(LIVE * TAB_MAX + 1);
	localparam int SUM_W = MAG_W + 1;
	localparam int P_W   = MAG_W + G2K_W;
	localparam int RW    = P_W - RND_SHIFT + 1;
	localparam logic [MASK_W-1:0] LIVE_MASK = MASK_W'((1 << LIVE) - 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_KEY    = 3'd1;
	localparam logic [2:0] S_DRAIN  = 3'd2;
	localparam logic [2:0] S_GAIN   = 3'd3;
	localparam logic [2:0] S_MSTART = 3'd4;
	localparam logic [2:0] S_SCALE  = 3'd5;
	localparam logic [2:0] S_OUT    = 3'd6;

	logic [2:0]            state_q;
	logic [STEP_W-1:0]     key_step_q [STEP_REGS];
	logic [VOL_W-1:0]      volume_q;
	logic [PHASE_BITS-1:0] key_phase_q [LIVE];
	logic [MASK_W-1:0]     mask_q;
	logic [KEY_W-1:0]      key_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [G2K_W-1:0]      gain2k_q;
	logic                  out_valid_q;
	logic [PCM_W-1:0]      pcm_q;
	logic                  clip_q;

	// key pipeline: s1 table index, s2 table word
	logic                  vld_s1;
	logic [QBITS-1:0]      idx_s1;
	logic                  neg_s1;
	logic                  vld_s2;
	logic [TAB_W-1:0]      tab_s2;
	logic                  neg_s2;

	tab_word_t             qtab [QSIZE];

	logic                  accept;
	logic                  out_free;
	logic                  held;
	logic [PHASE_BITS-1:0] ph_new;
	logic [SINE_ADDR_BITS-1:0] addr;
	logic [CNT_W-1:0]      cnt;
	logic [MAG_W-1:0]      sum_mag;
	logic signed [SUM_W-1:0] tab_ext;

	logic                  mul_start;
	logic [MAG_W-1:0]      mul_a;
	logic [G2K_W-1:0]      mul_b;
	logic                  mul_busy;
	logic [P_W-1:0]        mul_prod;

	logic [16:0]           gain_raw;
	logic [GAIN_W-1:0]     gain;
	logic [RW-1:0]         mag;
	logic                  clip_pos;
	logic                  clip_neg;
	logic [PCM_W-1:0]      pcm_next;
	logic                  clip_next;

	for (genvar gi = 0; gi < QSIZE; gi++) begin : g_qtab
		assign qtab[gi] = qtab_entry(gi, QBITS);
	end

	assign accept   = (state_q == S_IDLE) && key_valid;
	assign out_free = !out_valid_q || !pcm_stall;
	assign cnt      = CNT_W'($countones(key_mask & LIVE_MASK));

	assign held   = mask_q[STEP_IDX_W'(key_q)];
	assign ph_new = key_phase_q[key_q] + PHASE_BITS'(key_step_q[STEP_IDX_W'(key_q)]);
	assign addr   = ph_new[PHASE_BITS-1 -: SINE_ADDR_BITS];

	assign sum_mag = MAG_W'(sum_q[SUM_W-1] ? -sum_q : sum_q);
	assign tab_ext = SUM_W'(tab_s2);

	// multiplier: volume*recip while walking keys, then |sum|*gain*2000
	assign mul_start = accept || (state_q == S_MSTART);
	assign mul_a     = (state_q == S_IDLE) ? MAG_W'(volume_q) : sum_mag;
	assign mul_b     = (state_q == S_IDLE) ? G2K_W'(recip_q12(cnt)) : gain2k_q;

	psk_ser_mul #(
		.A_W (MAG_W),
		.B_W (G2K_W),
		.DIG (MUL_DIG)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	always_comb begin
		gain_raw = 17'((29'(mul_prod[27:0]) + 29'd2048) >> 12);
		gain = (gain_raw > 17'(GAIN_ONE)) ? GAIN_ONE : gain_raw[GAIN_W-1:0];
	end

	// (p + 2^26) >> 27 == (p >> 27) + p[26]
	always_comb begin
		mag = RW'(mul_prod[P_W-1:RND_SHIFT]) + RW'(mul_prod[RND_SHIFT-1]);
		clip_pos = mag > RW'(PCM_POS_MAX);
		clip_neg = mag > RW'(PCM_MID);
		if (sum_q[SUM_W-1]) begin
			clip_next = clip_neg;
			pcm_next  = clip_neg ? PCM_BOT : PCM_W'(RW'(PCM_MID) - mag);
		end else begin
			clip_next = clip_pos;
			pcm_next  = clip_pos ? PCM_TOP : PCM_W'(RW'(PCM_MID) + mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			key_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (key_valid) begin
						key_q   <= '0;
						state_q <= S_KEY;
					end
				end
				S_KEY: begin
					if (key_q == KEY_W'(LIVE - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						key_q <= key_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!vld_s1 && !vld_s2 && !mul_busy) begin
						state_q <= S_GAIN;
					end
				end
				S_GAIN:   state_q <= S_MSTART;
				S_MSTART: state_q <= S_SCALE;
				S_SCALE: begin
					if (!mul_busy) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STEP_REGS; k++) begin
				key_step_q[k] <= STEP_RESET[k];
			end
			volume_q <= VOL_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_VOLUME) begin
				volume_q <= cfg_data[VOL_W-1:0];
			end else begin
				key_step_q[cfg_index] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LIVE; k++) begin
				key_phase_q[k] <= '0;
			end
		end else if (state_q == S_KEY && held) begin
			key_phase_q[key_q] <= ph_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_KEY) && held;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		// odd quadrants mirror the index, upper half negates
		idx_s1 <= addr[SINE_ADDR_BITS-2] ? ~addr[QBITS-1:0] : addr[QBITS-1:0];
		neg_s1 <= addr[SINE_ADDR_BITS-1];
		tab_s2 <= qtab[idx_s1];
		neg_s2 <= neg_s1;
		if (accept) begin
			mask_q <= key_mask;
			sum_q  <= '0;
		end else if (vld_s2) begin
			sum_q <= neg_s2 ? sum_q - tab_ext : sum_q + tab_ext;
		end
		if (state_q == S_GAIN) begin
			gain2k_q <= G2K_W'(G2K_W'(gain) * AMP_SCALE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!pcm_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			pcm_q  <= pcm_next;
			clip_q <= clip_next;
		end
	end

	assign key_stall  = (state_q != S_IDLE);
	assign pcm_valid  = out_valid_q;
	assign pcm_sample = pcm_q;
	assign clipped    = clip_q;

endmodule

`default_nettype wire
